FILE: rtl/fsp_pkg.sv
// shared types, constants and decode helpers for the five-stage pipeline core
`timescale 1ns / 1ps
package fsp_pkg;
  localparam int INSTR_DEPTH = 64;
  localparam int DATA_DEPTH = 16;
  localparam int IAW = $clog2(INSTR_DEPTH);
  localparam int DAW = $clog2(DATA_DEPTH);

  localparam logic [1:0] CMD_INSTR = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_STEP = 2'd2;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_LW = 6'h23;
  localparam logic [5:0] OP_SW = 6'h2b;
  localparam logic [5:0] OP_BEQ = 6'h04;
  localparam logic [5:0] OP_BNE = 6'h05;
  localparam logic [5:0] OP_ADDI = 6'h08;
  localparam logic [5:0] OP_ANDI = 6'h0c;

  localparam logic [8:0] CTRL_RTYPE = 9'h182;
  localparam logic [8:0] CTRL_LW = 9'h02b;
  localparam logic [8:0] CTRL_SW = 9'h024;
  localparam logic [8:0] CTRL_BR = 9'h050;
  localparam logic [8:0] CTRL_ADDI = 9'h022;
  localparam logic [8:0] CTRL_ANDI = 9'h0e2;

  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR = 6'h25;
  localparam logic [5:0] FN_SLT = 6'h2a;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] slot;
    logic [31:0] word;
  } in_word_t;

  typedef struct packed {
    logic [7:0] fetch_address;
    logic reg_write;
    logic [4:0] reg_index;
    logic signed [31:0] reg_value;
    logic mem_write;
    logic [3:0] mem_index;
    logic signed [31:0] mem_value;
    logic stalled;
    logic branch_taken;
  } out_word_t;

  function automatic logic [8:0] control_of(input logic [31:0] ins);
    logic [8:0] c;
    unique case (ins[31:26])
      OP_RTYPE: c = (ins[5:0] != 6'd0) ? CTRL_RTYPE : 9'd0;
      OP_LW: c = CTRL_LW;
      OP_SW: c = CTRL_SW;
      OP_BEQ, OP_BNE: c = CTRL_BR;
      OP_ADDI: c = CTRL_ADDI;
      OP_ANDI: c = CTRL_ANDI;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] alu(input logic [1:0] op, input logic [5:0] funct,
                                      input logic [31:0] x, input logic [31:0] y);
    logic [31:0] r;
    priority case (1'b1)
      op == 2'd0: r = x + y;
      op == 2'd1: r = x - y;
      op == 2'd3: r = x & y;
      default: begin
        unique case (funct)
          FN_ADD: r = x + y;
          FN_SUB: r = x - y;
          FN_AND: r = x & y;
          FN_OR: r = x | y;
          FN_SLT: r = {31'd0, $signed(x) < $signed(y)};
          default: r = 32'd0;
        endcase
      end
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/fsp_stream_if.sv
// valid/ready channel carrying one word of a given payload type
`timescale 1ns / 1ps
interface fsp_in_if;
  import fsp_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fsp_out_if;
  import fsp_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/five_stage_pipeline_core_unit.sv
// top level: five-stage integer pipeline stepped by command words
`timescale 1ns / 1ps
// channels: cmd_in (sink) takes a word with command, slot and word; res_out
// (source) gives one result word for every command word taken.
// command 0 writes instruction memory, 1 writes data memory, 2 advances the
// pipeline by one step; the result carries write-back, store, stall and branch
// flags for that step, or just the fetch address for any other command.
// the result is registered and valid in the cycle after its command word is taken.
// throughput: one word per cycle while res_out takes results; all stage work for
// a word is done combinationally between the input handshake and the result register.
// stall: while res_out waits, cmd_in is held off unless the result register
// is being emptied that same cycle, so no word is lost.
// reset: synchronous; pipeline registers clear to bubbles, pc to zero, the
// register file and data memory to their preset values (per-entry valid
// bits stand for the preset until a word is written).
module five_stage_pipeline_core_unit (
  input logic clk,
  input logic rst,
  fsp_in_if.sink cmd_in,
  fsp_out_if.source res_out
);
  import fsp_pkg::*;

  logic out_valid;
  logic en;
  out_word_t result;

  assign cmd_in.ready = !out_valid || res_out.ready;
  assign en = cmd_in.valid && cmd_in.ready;
  assign res_out.valid = out_valid;
  assign res_out.data = result;

  fsp_core u_core (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_word(cmd_in.data),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_one_per_word: assert property (@(posedge clk) disable iff (rst)
    en |=> out_valid) else $error("result missing after accepted word");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_out.ready) |=> $stable(res_out.data)) else $error("held result changed");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_out.ready) |-> !cmd_in.ready) else $error("overrun of result");
endmodule

FILE: rtl/fsp_core.sv
// pipeline state and the combinational advance logic for one step
`timescale 1ns / 1ps
module fsp_core (
  input logic clk,
  input logic rst,
  input logic en,
  input fsp_pkg::in_word_t in_word,
  output fsp_pkg::out_word_t result
);
  import fsp_pkg::*;

  logic [31:0] imem [INSTR_DEPTH];
  logic [31:0] dmem [DATA_DEPTH];
  logic [31:0] rf [32];
  logic [INSTR_DEPTH-1:0] imem_valid;
  logic [DATA_DEPTH-1:0] dmem_valid;
  logic [31:0] rf_valid;

  logic [7:0] pc;
  logic [31:0] fd_instr;
  logic [7:0] fd_addr;
  logic [8:0] de_ctrl;
  logic [4:0] de_rs, de_rt, de_rd;
  logic [31:0] de_a, de_b, de_imm;
  logic [4:0] em_ctrl;
  logic [31:0] em_alu, em_wdata;
  logic [4:0] em_dest;
  logic [1:0] mw_ctrl;
  logic [31:0] mw_rdata, mw_alu;
  logic [4:0] mw_dest;
  logic br_pend;
  logic [7:0] br_tgt;

  function automatic logic [31:0] rf_init(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd1: v = 32'd9;
      5'd2: v = 32'd8;
      5'd3: v = 32'd7;
      5'd4: v = 32'd1;
      5'd5: v = 32'd2;
      5'd6: v = 32'd3;
      5'd7: v = 32'd4;
      5'd8: v = 32'd5;
      5'd9: v = 32'd6;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] dm_init(input logic [DAW-1:0] i);
    logic [31:0] v;
    unique case (32'(i))
      0: v = 32'd5;
      1: v = 32'd9;
      2: v = 32'd4;
      3: v = 32'd8;
      4: v = 32'd7;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  logic step;
  logic wb_we;
  logic [31:0] wb_val;
  logic [DAW-1:0] m_idx;
  logic [31:0] m_rd;
  logic m_we;
  logic [31:0] x, bval, y, ex_alu;
  logic [4:0] ex_dest;
  logic [7:0] pc_d;
  logic [31:0] ins;
  logic [4:0] d_rs, d_rt;
  logic [31:0] d_imm, d_a, d_b;
  logic taken, stall;
  logic [IAW-1:0] f_idx;
  out_word_t result_next;

  always_comb begin
    step = en && (in_word.command == CMD_STEP);
    wb_val = mw_ctrl[0] ? mw_rdata : mw_alu;
    wb_we = mw_ctrl[1] && (mw_dest != 5'd0);
    m_idx = em_alu[DAW+1:2];
    m_rd = dmem_valid[m_idx] ? dmem[m_idx] : dm_init(m_idx);
    m_we = em_ctrl[2];
    // forwarding: ex/mem value first, then write-back
    if (de_rs != 5'd0 && de_rs == em_dest && em_ctrl[1:0] != 2'd0) x = em_alu;
    else if (wb_we && de_rs == mw_dest) x = wb_val;
    else x = de_a;
    if (de_rt != 5'd0 && de_rt == em_dest && em_ctrl[1:0] != 2'd0) bval = em_alu;
    else if (wb_we && de_rt == mw_dest) bval = wb_val;
    else bval = de_b;
    y = de_ctrl[5] ? de_imm : bval;
    ex_alu = alu(de_ctrl[7:6], de_imm[5:0], x, y);
    ex_dest = de_ctrl[8] ? de_rd : de_rt;
    pc_d = br_pend ? br_tgt : pc;
    ins = br_pend ? 32'd0 : fd_instr;
    d_rs = ins[25:21];
    d_rt = ins[20:16];
    d_imm = {{16{ins[15]}}, ins[15:0]};
    // register file writes before it reads
    d_a = (wb_we && d_rs == mw_dest) ? wb_val : (rf_valid[d_rs] ? rf[d_rs] : rf_init(d_rs));
    d_b = (wb_we && d_rt == mw_dest) ? wb_val : (rf_valid[d_rt] ? rf[d_rt] : rf_init(d_rt));
    taken = (ins[31:26] == OP_BEQ && d_a == d_b) || (ins[31:26] == OP_BNE && d_a != d_b);
    stall = de_ctrl[3] && (de_rt == d_rs || de_rt == d_rt);
    f_idx = pc_d[IAW+1:2];
    result_next = '0;
    result_next.fetch_address = fd_addr;
    if (step) begin
      result_next.fetch_address = stall ? fd_addr : pc_d;
      result_next.reg_write = wb_we;
      result_next.reg_index = wb_we ? mw_dest : 5'd0;
      result_next.reg_value = wb_we ? wb_val : 32'd0;
      result_next.mem_write = m_we;
      result_next.mem_index = m_we ? 4'(m_idx) : 4'd0;
      result_next.mem_value = m_we ? em_wdata : 32'd0;
      result_next.stalled = stall;
      result_next.branch_taken = taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      imem_valid <= '0;
      dmem_valid <= '0;
      rf_valid <= '0;
      pc <= '0;
      fd_instr <= '0;
      fd_addr <= '0;
      de_ctrl <= '0;
      de_rs <= '0;
      de_rt <= '0;
      de_rd <= '0;
      de_a <= '0;
      de_b <= '0;
      de_imm <= '0;
      em_ctrl <= '0;
      em_alu <= '0;
      em_wdata <= '0;
      em_dest <= '0;
      mw_ctrl <= '0;
      mw_rdata <= '0;
      mw_alu <= '0;
      mw_dest <= '0;
      br_pend <= 1'b0;
      br_tgt <= '0;
      result <= '0;
    end else if (en) begin
      result <= result_next;
      if (in_word.command == CMD_INSTR) begin
        imem[in_word.slot[IAW-1:0]] <= in_word.word;
        imem_valid[in_word.slot[IAW-1:0]] <= 1'b1;
      end else if (in_word.command == CMD_DATA) begin
        dmem[in_word.slot[DAW-1:0]] <= in_word.word;
        dmem_valid[in_word.slot[DAW-1:0]] <= 1'b1;
      end else if (step) begin
        if (wb_we) begin
          rf[mw_dest] <= wb_val;
          rf_valid[mw_dest] <= 1'b1;
        end
        if (m_we) begin
          dmem[m_idx] <= em_wdata;
          dmem_valid[m_idx] <= 1'b1;
        end
        mw_dest <= em_dest;
        mw_alu <= em_alu;
        mw_ctrl <= em_ctrl[1:0];
        mw_rdata <= em_ctrl[3] ? m_rd : 32'd0;
        em_alu <= ex_alu;
        em_wdata <= bval;
        em_dest <= ex_dest;
        em_ctrl <= de_ctrl[4:0];
        de_rs <= d_rs;
        de_rt <= d_rt;
        de_rd <= ins[15:11];
        de_imm <= d_imm;
        de_a <= d_a;
        de_b <= d_b;
        de_ctrl <= stall ? 9'd0 : control_of(ins);
        br_tgt <= pc_d + {d_imm[5:0], 2'b00};
        br_pend <= taken;
        if (!stall) begin
          fd_instr <= imem_valid[f_idx] ? imem[f_idx] : 32'd0;
          fd_addr <= pc_d;
          pc <= pc_d + 8'd4;
        end else begin
          fd_instr <= ins;
          pc <= pc_d;
        end
      end
    end
  end

  a_r0_never: assert property (@(posedge clk) disable iff (rst)
    result.reg_write |-> result.reg_index != 5'd0) else $error("write to r0 reported");
  a_wb_zero: assert property (@(posedge clk) disable iff (rst)
    !result.reg_write |-> result.reg_value == 32'd0) else $error("idle write-back nonzero");
  a_stall_bubble: assert property (@(posedge clk) disable iff (rst)
    (en && step && stall) |=> de_ctrl == 9'd0) else $error("stall left live decode");
  a_branch_flush: assert property (@(posedge clk) disable iff (rst)
    (en && step && taken) |=> br_pend) else $error("taken branch not pending");
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the five-stage pipeline core unit
`timescale 1ns / 1ps
module testbench;
  import fsp_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam int NUM_RANDOM = 1950;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fsp_in_if cmd_ch();
  fsp_out_if res_ch();

  five_stage_pipeline_core_unit uut (
    .clk(clk),
    .rst(rst),
    .cmd_in(cmd_ch.sink),
    .res_out(res_ch.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] p_imem [INSTR_DEPTH];
  logic [31:0] p_regs [32];
  logic [31:0] p_dmem [DATA_DEPTH];
  logic [7:0] p_pc, p_fd_addr, p_btarget;
  logic [31:0] p_fd_ins;
  logic p_bpend;
  logic [8:0] de_ctrl;
  logic [4:0] de_rs, de_rt, de_rd;
  logic [31:0] de_a, de_b, de_imm;
  logic [4:0] em_ctrl, em_dest;
  logic [31:0] em_alu, em_wdata;
  logic [1:0] mw_ctrl;
  logic [4:0] mw_dest;
  logic [31:0] mw_rdata, mw_alu;

  out_word_t expected_q[$];
  int mismatches = 0;
  int sink_wait = 0;

  function automatic logic [8:0] ctrl_for(input logic [31:0] ins);
    case (ins[31:26])
      OP_RTYPE: return (ins[5:0] != 6'd0) ? CTRL_RTYPE : 9'd0;
      OP_LW: return CTRL_LW;
      OP_SW: return CTRL_SW;
      OP_BEQ, OP_BNE: return CTRL_BR;
      OP_ADDI: return CTRL_ADDI;
      OP_ANDI: return CTRL_ANDI;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [31:0] exec_op(input logic [1:0] op, input logic [5:0] fn,
                                          input logic [31:0] x, input logic [31:0] y);
    if (op == 2'd0) return x + y;
    if (op == 2'd1) return x - y;
    if (op == 2'd3) return x & y;
    case (fn)
      FN_ADD: return x + y;
      FN_SUB: return x - y;
      FN_AND: return x & y;
      FN_OR: return x | y;
      FN_SLT: return ($signed(x) < $signed(y)) ? 32'd1 : 32'd0;
      default: return 32'd0;
    endcase
  endfunction

  task automatic core_reset();
    for (int i = 0; i < INSTR_DEPTH; i++) p_imem[i] = '0;
    for (int i = 0; i < 32; i++) p_regs[i] = '0;
    for (int i = 0; i < DATA_DEPTH; i++) p_dmem[i] = '0;
    p_regs[1] = 9; p_regs[2] = 8; p_regs[3] = 7; p_regs[4] = 1; p_regs[5] = 2;
    p_regs[6] = 3; p_regs[7] = 4; p_regs[8] = 5; p_regs[9] = 6;
    p_dmem[0] = 5; p_dmem[1] = 9; p_dmem[2] = 4; p_dmem[3] = 8; p_dmem[4] = 7;
    p_pc = '0; p_fd_addr = '0; p_btarget = '0; p_fd_ins = '0; p_bpend = 1'b0;
    de_ctrl = '0; de_rs = '0; de_rt = '0; de_rd = '0; de_a = '0; de_b = '0; de_imm = '0;
    em_ctrl = '0; em_dest = '0; em_alu = '0; em_wdata = '0;
    mw_ctrl = '0; mw_dest = '0; mw_rdata = '0; mw_alu = '0;
  endtask

  function automatic out_word_t core_step(input in_word_t w);
    out_word_t r;
    logic [31:0] wbv, x, bv, y, ins, nalu;
    logic [4:0] wbd, old_rt, n_rs, n_rt;
    logic [1:0] nmw_ctrl;
    logic [4:0] nmw_dest;
    logic [DAW-1:0] idx;
    logic [8:0] c;
    logic stall;
    r = '0;
    if (w.command == CMD_INSTR) p_imem[w.slot % INSTR_DEPTH] = w.word;
    else if (w.command == CMD_DATA) p_dmem[w.slot % DATA_DEPTH] = w.word;
    else if (w.command == CMD_STEP) begin
      wbv = mw_ctrl[0] ? mw_rdata : mw_alu;
      wbd = mw_dest;
      if (mw_ctrl[1] && wbd != 5'd0) begin
        p_regs[wbd] = wbv;
        r.reg_write = 1'b1; r.reg_index = wbd; r.reg_value = wbv;
      end
      // memory stage
      idx = em_alu[DAW+1:2];
      nmw_dest = em_dest; nalu = em_alu; nmw_ctrl = em_ctrl[1:0];
      mw_rdata = em_ctrl[3] ? p_dmem[idx] : 32'd0;
      if (em_ctrl[2]) begin
        p_dmem[idx] = em_wdata;
        r.mem_write = 1'b1; r.mem_index = idx; r.mem_value = em_wdata;
      end
      mw_dest = nmw_dest; mw_alu = nalu; mw_ctrl = nmw_ctrl;
      // execute with forwarding
      x = de_a;
      if (de_rs != 5'd0 && de_rs == mw_dest && mw_ctrl != 2'd0) x = mw_alu;
      else if (r.reg_write && de_rs == wbd) x = wbv;
      bv = de_b;
      if (de_rt != 5'd0 && de_rt == mw_dest && mw_ctrl != 2'd0) bv = mw_alu;
      else if (r.reg_write && de_rt == wbd) bv = wbv;
      y = de_ctrl[5] ? de_imm : bv;
      em_alu = exec_op(de_ctrl[7:6], de_imm[5:0], x, y);
      em_wdata = bv;
      em_dest = de_ctrl[8] ? de_rd : de_rt;
      em_ctrl = de_ctrl[4:0];
      old_rt = de_rt;
      // decode
      if (p_bpend) begin
        p_pc = p_btarget; p_fd_ins = '0; p_bpend = 1'b0;
      end
      ins = p_fd_ins;
      c = ctrl_for(ins);
      n_rs = ins[25:21]; n_rt = ins[20:16];
      de_rs = n_rs; de_rt = n_rt; de_rd = ins[15:11];
      de_imm = {{16{ins[15]}}, ins[15:0]};
      de_a = p_regs[n_rs]; de_b = p_regs[n_rt];
      p_btarget = p_pc + {de_imm[5:0], 2'b00};
      if ((ins[31:26] == OP_BEQ && de_a == de_b) || (ins[31:26] == OP_BNE && de_a != de_b)) begin
        p_bpend = 1'b1; r.branch_taken = 1'b1;
      end
      stall = em_ctrl[3] && (old_rt == n_rs || old_rt == n_rt);
      de_ctrl = stall ? 9'd0 : c;
      r.stalled = stall;
      if (!stall) begin
        p_fd_ins = p_imem[p_pc[7:2] % INSTR_DEPTH];
        p_fd_addr = p_pc;
        p_pc = p_pc + 8'd4;
      end
    end
    r.fetch_address = p_fd_addr;
    return r;
  endfunction

  function automatic logic [31:0] rtype(input logic [4:0] rs, rt, rd, input logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs, rt,
                                        input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // mostly well-formed instructions on low registers, some raw noise
  function automatic logic [31:0] rand_instr();
    logic [4:0] rs, rt, rd;
    logic [15:0] imm;
    rs = 5'($urandom_range(0, 9)); rt = 5'($urandom_range(0, 9)); rd = 5'($urandom_range(0, 9));
    imm = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
    case ($urandom_range(0, 14))
      0: return rtype(rs, rt, rd, FN_ADD);
      1: return rtype(rs, rt, rd, FN_SUB);
      2: return rtype(rs, rt, rd, FN_AND);
      3: return rtype(rs, rt, rd, FN_OR);
      4: return rtype(rs, rt, rd, FN_SLT);
      5, 6: return itype(OP_LW, rs, rt, imm);
      7: return itype(OP_SW, rs, rt, imm);
      8: return itype(OP_BEQ, rs, rt, 16'($signed($urandom_range(0, 6)) - 3));
      9: return itype(OP_BNE, rs, rt, 16'($signed($urandom_range(0, 6)) - 3));
      10: return itype(OP_ADDI, rs, rt, imm);
      11: return itype(OP_ANDI, rs, rt, imm);
      12: return rtype(rs, rt, rd, 6'($urandom));
      13: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // valid stays high into the next word when there is no gap
  task automatic send_word(input in_word_t w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= w;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_q.insert(expected_q.size(), core_step(w));
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_checked(input in_word_t w, input out_word_t exp_r);
    out_word_t got;
    send_word(w);
    got = expected_q[$];
    if (got != exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row mismatch: table %h predictor %h", exp_r, got);
    end
  endtask

  // sink side: ready is held low for a random wait chosen after each word taken
  always @(posedge clk) begin
    out_word_t e;
    if (rst) res_ch.ready <= 1'b0;
    else begin
      if (res_ch.valid && res_ch.ready) begin
        sink_wait = $urandom_range(0, 7);
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", res_ch.data);
        end else begin
          e = expected_q.pop_front();
          if (res_ch.data !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected fa=%0d we=%b ri=%0d rv=%h mw=%b mi=%0d mv=%h st=%b br=%b, got fa=%0d we=%b ri=%0d rv=%h mw=%b mi=%0d mv=%h st=%b br=%b",
                e.fetch_address, e.reg_write, e.reg_index, e.reg_value, e.mem_write,
                e.mem_index, e.mem_value, e.stalled, e.branch_taken,
                res_ch.data.fetch_address, res_ch.data.reg_write, res_ch.data.reg_index,
                res_ch.data.reg_value, res_ch.data.mem_write, res_ch.data.mem_index,
                res_ch.data.mem_value, res_ch.data.stalled, res_ch.data.branch_taken);
          end
        end
      end
      if (sink_wait > 0) begin
        sink_wait--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  typedef struct {
    in_word_t w;
    bit has_exp;
    out_word_t r;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    in_word_t w;
    out_word_t z;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    core_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    z = '0;
    // after reset: load and ignored commands give only the fetch address
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd0, rtype(5'd1, 5'd2, 5'd10, FN_ADD)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd63, 32'hffff_ffff}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd1, itype(OP_LW, 5'd0, 5'd11, 16'd4)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd2, rtype(5'd11, 5'd10, 5'd12, FN_SUB)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd3, itype(OP_SW, 5'd0, 5'd12, 16'hfffc)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd4, rtype(5'd12, 5'd1, 5'd13, FN_SLT)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd5, itype(OP_ANDI, 5'd1, 5'd0, 16'h8001)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd6, itype(OP_BEQ, 5'd0, 5'd0, 16'd2)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd7, rtype(5'd1, 5'd2, 5'd14, FN_OR)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd9, itype(OP_BNE, 5'd1, 5'd2, 16'hfff0)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd10, rtype(5'd1, 5'd2, 5'd15, FN_AND)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd11, itype(OP_ADDI, 5'd2, 5'd16, 16'h7fff)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_INSTR, 6'd12, rtype(5'd1, 5'd2, 5'd17, 6'h3f)}, 1, z});
    rows.insert(rows.size(), '{'{CMD_DATA, 6'd63, 32'h8000_0000}, 1, z});
    rows.insert(rows.size(), '{'{CMD_IGNORED, 6'd21, 32'h5555_aaaa}, 1, z});
    for (int i = 0; i < 10; i++) rows.insert(rows.size(), '{'{CMD_STEP, 6'd0, 32'd0}, 0, z});
    foreach (rows[i]) begin
      if (rows[i].has_exp) send_checked(rows[i].w, rows[i].r);
      else send_word(rows[i].w);
    end
    // random programs: load code, run, repeat
    for (int n = 0; n < NUM_RANDOM;) begin
      int len;
      len = $urandom_range(4, 16);
      for (int i = 0; i < len; i++) begin
        w.command = CMD_INSTR; w.slot = 6'($urandom_range(0, 20)); w.word = rand_instr();
        if ($urandom_range(0, 9) == 0) w.slot = 6'($urandom);
        send_word(w); n++;
      end
      if ($urandom_range(0, 2) == 0) begin
        w.command = CMD_DATA; w.slot = 6'($urandom); w.word = $urandom;
        send_word(w); n++;
      end
      for (int i = $urandom_range(8, 30); i > 0; i--) begin
        w.command = CMD_STEP; w.slot = 6'($urandom); w.word = $urandom;
        if ($urandom_range(0, 29) == 0) w.command = CMD_IGNORED;
        send_word(w); n++;
      end
      if (n > 900 && n < 960) drain();
    end
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
